>>> rtl/xchacha20_stream_cipher_unit_macros.svh
// assertion macros for the cipher unit
`ifndef XCHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`define XCHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define XCC_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define XCC_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define XCC_ASSERT_IMP(label, clk, rst_n, a, b)
`define XCC_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

>>> rtl/xcc_pkg.sv
package xcc_pkg;
	localparam int NumRegs = 7;
	localparam int RegIdxW = 3;
	localparam logic [RegIdxW-1:0] RegKey0   = 3'd0;
	localparam logic [RegIdxW-1:0] RegKey1   = 3'd1;
	localparam logic [RegIdxW-1:0] RegKey2   = 3'd2;
	localparam logic [RegIdxW-1:0] RegKey3   = 3'd3;
	localparam logic [RegIdxW-1:0] RegNonce0 = 3'd4;
	localparam logic [RegIdxW-1:0] RegNonce1 = 3'd5;
	localparam logic [RegIdxW-1:0] RegNonce2 = 3'd6;

	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HROUND,
		ST_HDONE,
		ST_BROUND,
		ST_FEED,
		ST_OUT
	} ctl_state_t;

	// quarter-round selection for step 0..7 of a double round
	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
	} qr_idx_t;

	function automatic qr_idx_t qr_index(input logic [2:0] step);
		qr_idx_t r;
		case (step)
			3'd0: r = '{4'd0, 4'd4, 4'd8,  4'd12};
			3'd1: r = '{4'd1, 4'd5, 4'd9,  4'd13};
			3'd2: r = '{4'd2, 4'd6, 4'd10, 4'd14};
			3'd3: r = '{4'd3, 4'd7, 4'd11, 4'd15};
			3'd4: r = '{4'd0, 4'd5, 4'd10, 4'd15};
			3'd5: r = '{4'd1, 4'd6, 4'd11, 4'd12};
			3'd6: r = '{4'd2, 4'd7, 4'd8,  4'd13};
			3'd7: r = '{4'd3, 4'd4, 4'd9,  4'd14};
			default: r = '{4'd0, 4'd4, 4'd8, 4'd12};
		endcase
		return r;
	endfunction
endpackage

>>> rtl/xcc_byte_if.sv
interface xcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;
	logic [7:0] out_byte;
	modport source (output valid, output data_byte, output first, output out_byte,
		input ready);
	modport sink (input valid, input data_byte, input first, input out_byte,
		output ready);
endinterface

>>> rtl/xcc_cfg_if.sv
interface xcc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/xcc_qround.sv
module xcc_qround
	import xcc_pkg::*;
(
	input  word_t a_in,
	input  word_t b_in,
	input  word_t c_in,
	input  word_t d_in,
	output word_t a_out,
	output word_t b_out,
	output word_t c_out,
	output word_t d_out
);
	word_t a1, d1, c1, b1, a2, d2, c2, b2;
	// one full quarter round: four adds on 32-bit words
	always_comb begin
		a1 = a_in + b_in;
		d1 = d_in ^ a1;
		d1 = {d1[15:0], d1[31:16]};
		c1 = c_in + d1;
		b1 = b_in ^ c1;
		b1 = {b1[19:0], b1[31:20]};
		a2 = a1 + b1;
		d2 = d1 ^ a2;
		d2 = {d2[23:0], d2[31:24]};
		c2 = c1 + d2;
		b2 = b1 ^ c2;
		b2 = {b2[24:0], b2[31:25]};
		a_out = a2;
		b_out = b2;
		c_out = c2;
		d_out = d2;
	end
endmodule

>>> rtl/xchacha20_stream_cipher_unit.sv
// channel | dir | beat contents
// in      | in  | data_byte, first
// out     | out | out_byte
// cfg     | in  | index, wdata (64-bit register)
// A byte at position 1..63 of a block passes through the accept, the output register load and
// the out beat before the next accept; the out beat waits for out.ready.
// A byte at position 0 adds 80 quarter-round steps on the shared unit and a feed-forward pass
// over the 16 words; a first byte adds 80 more steps for the subkey and a latch state.
// Reset zeroes subkey, position and config registers, sets the counter to 1; no clearing pass.
// in is held off while a byte waits in the output register or the sequencer is not idle.
`include "xchacha20_stream_cipher_unit_macros.svh"
module xchacha20_stream_cipher_unit
	import xcc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	xcc_byte_if.sink   in,
	xcc_byte_if.source out,
	xcc_cfg_if.sink    cfg
);
	logic [63:0] regs_q [NumRegs];
	word_t       subkey_q [8];
	word_t       counter_q;
	logic [5:0]  pos_q;
	state_t      w_q;
	word_t       ks_q [16];
	ctl_state_t  state_q, state_d;
	logic [6:0]  step_q;
	logic [7:0]  data_q;
	logic [7:0]  obyte_q;
	logic        ovalid_q;
	logic        in_fire;
	qr_idx_t     qi;
	word_t       qa, qb, qc, qd;
	word_t       init_w [16];

	assign cfg.ready = 1'b1;
	assign in.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign in_fire = in.valid && in.ready;
	assign out.valid = ovalid_q;
	assign out.out_byte = obyte_q;
	assign out.data_byte = 8'd0;
	assign out.first = 1'b0;

	// block input words
	always_comb begin
		init_w[0] = Sigma0; init_w[1] = Sigma1; init_w[2] = Sigma2; init_w[3] = Sigma3;
		for (int i = 0; i < 8; i++) init_w[4+i] = subkey_q[i];
		init_w[12] = counter_q;
		init_w[13] = '0;
		init_w[14] = regs_q[RegNonce2][31:0];
		init_w[15] = regs_q[RegNonce2][63:32];
	end

	// shared quarter-round unit
	assign qi = qr_index(step_q[2:0]);
	xcc_qround u_qr (
		.a_in(w_q[qi.a]), .b_in(w_q[qi.b]), .c_in(w_q[qi.c]), .d_in(w_q[qi.d]),
		.a_out(qa), .b_out(qb), .c_out(qc), .d_out(qd)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
		end else if (cfg.valid && int'(cfg.index) < NumRegs) begin
			regs_q[cfg.index] <= cfg.wdata;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in.first) state_d = ST_HROUND;
					else if (pos_q == 6'd0) state_d = ST_BROUND;
					else state_d = ST_OUT;
				end
			end
			ST_HROUND: if (step_q == 7'd79) state_d = ST_HDONE;
			ST_HDONE:  state_d = ST_BROUND;
			ST_BROUND: if (step_q == 7'd79) state_d = ST_FEED;
			ST_FEED:   if (step_q[3:0] == 4'd15) state_d = ST_OUT;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) subkey_q[i] <= '0;
			counter_q <= 32'd1;
			pos_q <= '0;
			step_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out.valid && out.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_fire) begin
						data_q <= in.data_byte;
						if (in.first) begin
							w_q[0] <= Sigma0; w_q[1] <= Sigma1;
							w_q[2] <= Sigma2; w_q[3] <= Sigma3;
							for (int i = 0; i < 4; i++) begin
								w_q[4+2*i] <= regs_q[i][31:0];
								w_q[5+2*i] <= regs_q[i][63:32];
							end
							w_q[12] <= regs_q[RegNonce0][31:0];
							w_q[13] <= regs_q[RegNonce0][63:32];
							w_q[14] <= regs_q[RegNonce1][31:0];
							w_q[15] <= regs_q[RegNonce1][63:32];
						end else if (pos_q == 6'd0) begin
							for (int i = 0; i < 16; i++) w_q[i] <= init_w[i];
						end
					end
				end
				ST_HROUND, ST_BROUND: begin
					w_q[qi.a] <= qa; w_q[qi.b] <= qb; w_q[qi.c] <= qc; w_q[qi.d] <= qd;
					step_q <= (step_q == 7'd79) ? 7'd0 : step_q + 7'd1;
				end
				ST_HDONE: begin
					for (int i = 0; i < 4; i++) begin
						subkey_q[i] <= w_q[i];
						subkey_q[4+i] <= w_q[12+i];
					end
					counter_q <= 32'd1;
					pos_q <= '0;
					// build block from new subkey and counter one
					w_q[0] <= Sigma0; w_q[1] <= Sigma1; w_q[2] <= Sigma2; w_q[3] <= Sigma3;
					for (int i = 0; i < 4; i++) begin
						w_q[4+i] <= w_q[i];
						w_q[8+i] <= w_q[12+i];
					end
					w_q[12] <= 32'd1;
					w_q[13] <= '0;
					w_q[14] <= regs_q[RegNonce2][31:0];
					w_q[15] <= regs_q[RegNonce2][63:32];
				end
				ST_FEED: begin
					ks_q[step_q[3:0]] <= w_q[step_q[3:0]] + init_w[step_q[3:0]];
					step_q <= step_q + 7'd1;
					if (step_q[3:0] == 4'd15) counter_q <= counter_q + 32'd1;
				end
				ST_OUT: begin
					obyte_q <= data_q ^ ks_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8];
					ovalid_q <= 1'b1;
					pos_q <= pos_q + 6'd1;
				end
				default: ;
			endcase
		end
	end

	`XCC_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !in.ready)
	`XCC_ASSERT_NXT(a_out_follows, clk, arst_n, state_q == ST_OUT, ovalid_q)
	`XCC_ASSERT_IMP(a_step_range, clk, arst_n, state_q == ST_BROUND, step_q < 7'd80)
endmodule
